/* hdl/pwtd_pkg.sv */
package pwtd_pkg;

    // configuration register indexes
    localparam logic [2:0] CFG_GLITCH_MIN  = 3'd0;
    localparam logic [2:0] CFG_ZERO_MIN    = 3'd1;
    localparam logic [2:0] CFG_ZERO_MAX    = 3'd2;
    localparam logic [2:0] CFG_ONE_MIN     = 3'd3;
    localparam logic [2:0] CFG_ONE_MAX     = 3'd4;
    localparam logic [2:0] CFG_START_MIN   = 3'd5;
    localparam logic [2:0] CFG_START_MAX   = 3'd6;
    localparam logic [2:0] CFG_REPLY_TMO   = 3'd7;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register reset values
    localparam logic [15:0] RST_GLITCH_MIN = 16'd1000;
    localparam logic [15:0] RST_ZERO_MIN   = 16'd1000;
    localparam logic [15:0] RST_ZERO_MAX   = 16'd2999;
    localparam logic [15:0] RST_ONE_MIN    = 16'd3000;
    localparam logic [15:0] RST_ONE_MAX    = 16'd4999;
    localparam logic [15:0] RST_START_MIN  = 16'd5000;
    localparam logic [15:0] RST_START_MAX  = 16'd6999;
    localparam logic [15:0] RST_REPLY_TMO  = 16'd20000;

    // repeat gap window
    localparam logic [31:0] GAP_MIN_US = 32'd10000;
    localparam logic [31:0] GAP_MAX_US = 32'd60000;

    // data bit counts of the three frame kinds
    localparam logic [5:0] BITS_LONG  = 6'd32;
    localparam logic [5:0] BITS_SHORT = 6'd16;
    localparam logic [5:0] BITS_REPLY = 6'd4;

    localparam int QUEUE_DEPTH_DEF = 2;

    // classified interval handed from front to back
    typedef struct packed {
        logic is_start;
        logic bit_valid;
        logic bit_val;
        logic timeout;
        logic gap_in;
        logic gap_over;
    } token_t;

    typedef enum logic [3:0] {
        PH_WAIT   = 4'b0001,
        PH_LENGTH = 4'b0010,
        PH_DATA   = 4'b0100,
        PH_PARITY = 4'b1000
    } phase_t;

endpackage

/* hdl/pwtd_front.sv */
module pwtd_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_we,
    input  logic [pwtd_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [pwtd_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [31:0]                         s_edge_time_us,
    input  logic                                q_full,
    output logic                                q_push,
    output pwtd_pkg::token_t                    q_token
);
    import pwtd_pkg::*;

    logic [15:0] glitch_min_reg, zero_min_reg, zero_max_reg, one_min_reg;
    logic [15:0] one_max_reg, start_min_reg, start_max_reg, reply_tmo_reg;
    logic [31:0] last_edge_reg, last_edge_next;
    logic [31:0] span;
    logic        keep, zero_hit, one_hit, start_hit, accept;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            glitch_min_reg <= RST_GLITCH_MIN;
            zero_min_reg   <= RST_ZERO_MIN;
            zero_max_reg   <= RST_ZERO_MAX;
            one_min_reg    <= RST_ONE_MIN;
            one_max_reg    <= RST_ONE_MAX;
            start_min_reg  <= RST_START_MIN;
            start_max_reg  <= RST_START_MAX;
            reply_tmo_reg  <= RST_REPLY_TMO;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_GLITCH_MIN: glitch_min_reg <= cfg_wdata;
                CFG_ZERO_MIN:   zero_min_reg   <= cfg_wdata;
                CFG_ZERO_MAX:   zero_max_reg   <= cfg_wdata;
                CFG_ONE_MIN:    one_min_reg    <= cfg_wdata;
                CFG_ONE_MAX:    one_max_reg    <= cfg_wdata;
                CFG_START_MIN:  start_min_reg  <= cfg_wdata;
                CFG_START_MAX:  start_max_reg  <= cfg_wdata;
                CFG_REPLY_TMO:  reply_tmo_reg  <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // interval since the last kept edge and its classes
    always_comb begin
        span      = s_edge_time_us - last_edge_reg;
        keep      = span >= {16'd0, glitch_min_reg};
        zero_hit  = (span >= {16'd0, zero_min_reg}) && (span <= {16'd0, zero_max_reg});
        one_hit   = (span >= {16'd0, one_min_reg}) && (span <= {16'd0, one_max_reg});
        start_hit = (span >= {16'd0, start_min_reg}) && (span <= {16'd0, start_max_reg});

        q_token.is_start  = start_hit;
        q_token.bit_valid = zero_hit || one_hit;
        q_token.bit_val   = !zero_hit;
        q_token.timeout   = span > {16'd0, reply_tmo_reg};
        q_token.gap_in    = (span >= GAP_MIN_US) && (span <= GAP_MAX_US);
        q_token.gap_over  = span > GAP_MAX_US;
    end

    // glitches are accepted but never queued
    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign q_push  = accept && keep;

    always_comb begin
        last_edge_next = last_edge_reg;
        if (q_push) begin
            last_edge_next = s_edge_time_us;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_edge_reg <= 32'd0;
        end else begin
            last_edge_reg <= last_edge_next;
        end
    end

endmodule

/* hdl/pwtd_queue.sv */
module pwtd_queue #(
    parameter int QUEUE_DEPTH = pwtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  pwtd_pkg::token_t push_token,
    output logic             full,
    input  logic             pop,
    output logic             head_valid,
    output pwtd_pkg::token_t head_token
);
    import pwtd_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

    token_t            slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next, rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full       = count_reg == CNT_FULL;
    assign head_valid = count_reg != '0;
    assign head_token = slot_reg[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_token;
        end
    end

    // pointers and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef ASSERT_OFF
    a_no_push_full: assert property (@(posedge aclk) disable iff (!aresetn)
        full |-> !push || pop)
        else $error("queue written while full");
    a_no_pop_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> head_valid)
        else $error("queue read while empty");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");
`endif

endmodule

/* hdl/pwtd_back.sv */
module pwtd_back (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    input  pwtd_pkg::token_t in_token,
    output logic             in_pop,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [31:0]      m_frame_word,
    output logic             m_long_frame,
    output logic             m_is_reply,
    output logic             m_is_repeat
);
    import pwtd_pkg::*;

    phase_t      phase_reg, phase_next;
    logic [5:0]  exp_reg, exp_next, taken_reg, taken_next, taken_inc;
    logic [31:0] shift_reg, shift_next, last_word_reg, last_word_next;
    logic        long_reg, long_next, gap_reg, gap_next, await_reg, await_next;
    logic        await_eff, gap_eff, good, reply, emit;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_word_reg;
    logic        out_long_reg, out_reply_reg, out_rep_reg;
    logic        rep;

    // take a token whenever the output register is free or draining
    assign in_pop = in_valid && (!out_valid_reg || m_ready);

    // frame sequencer
    always_comb begin
        phase_next     = phase_reg;
        exp_next       = exp_reg;
        taken_next     = taken_reg;
        shift_next     = shift_reg;
        long_next      = long_reg;
        last_word_next = last_word_reg;
        emit           = 1'b0;

        await_eff = await_reg && !in_token.timeout;
        gap_eff   = in_token.gap_in ? 1'b1 : (in_token.gap_over ? 1'b0 : gap_reg);
        taken_inc = taken_reg + 6'd1;
        good      = ((^shift_reg) ^ 1'b1) == in_token.bit_val;
        reply     = (exp_reg == BITS_REPLY) || ((exp_reg == BITS_LONG) && await_eff);
        rep       = (last_word_reg == shift_reg) && gap_eff;
        gap_next  = gap_eff;
        await_next = await_eff;

        if (in_token.is_start) begin
            shift_next = 32'd0;
            long_next  = 1'b0;
            taken_next = 6'd0;
            phase_next = PH_LENGTH;
        end else if (phase_reg == PH_WAIT) begin
            phase_next = PH_WAIT;
        end else if (!in_token.bit_valid) begin
            phase_next = PH_WAIT;
        end else begin
            case (phase_reg)
                PH_LENGTH: begin
                    long_next  = in_token.bit_val;
                    exp_next   = in_token.bit_val ? BITS_LONG
                               : (await_eff ? BITS_REPLY : BITS_SHORT);
                    taken_next = 6'd0;
                    phase_next = PH_DATA;
                end
                PH_DATA: begin
                    shift_next = {shift_reg[30:0], in_token.bit_val};
                    taken_next = taken_inc;
                    if (taken_inc >= exp_reg) begin
                        phase_next = PH_PARITY;
                    end
                end
                PH_PARITY: begin
                    phase_next = PH_WAIT;
                    if (good) begin
                        emit           = 1'b1;
                        last_word_next = shift_reg;
                        gap_next       = 1'b0;
                        await_next     = !reply;
                    end
                end
                default: begin
                    phase_next = PH_WAIT;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_WAIT;
            exp_reg       <= 6'd0;
            taken_reg     <= 6'd0;
            shift_reg     <= 32'd0;
            long_reg      <= 1'b0;
            gap_reg       <= 1'b0;
            await_reg     <= 1'b0;
            last_word_reg <= 32'd0;
        end else if (in_pop) begin
            phase_reg     <= phase_next;
            exp_reg       <= exp_next;
            taken_reg     <= taken_next;
            shift_reg     <= shift_next;
            long_reg      <= long_next;
            gap_reg       <= gap_next;
            await_reg     <= await_next;
            last_word_reg <= last_word_next;
        end
    end

    // output register
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (in_pop && emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_pop && emit) begin
            out_word_reg  <= shift_reg;
            out_long_reg  <= long_reg;
            out_reply_reg <= reply;
            out_rep_reg   <= rep;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_frame_word = out_word_reg;
    assign m_long_frame = out_long_reg;
    assign m_is_reply   = out_reply_reg;
    assign m_is_repeat  = out_rep_reg;

`ifndef ASSERT_OFF
    a_exp_known: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA || phase_reg == PH_PARITY) |->
        (exp_reg == BITS_LONG || exp_reg == BITS_SHORT || exp_reg == BITS_REPLY))
        else $error("bit count not a frame length");
    a_data_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_DATA |-> taken_reg < exp_reg)
        else $error("data phase past expected bits");
    a_parity_count: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PARITY |-> taken_reg == exp_reg)
        else $error("parity phase with wrong bit count");
    a_long_len: assert property (@(posedge aclk) disable iff (!aresetn)
        (long_reg && (phase_reg == PH_DATA || phase_reg == PH_PARITY)) |->
        exp_reg == BITS_LONG)
        else $error("long frame without 32 data bits");
`endif

endmodule

/* hdl/pulse_width_telegram_decoder.sv */
// Pulse-width telegram decoder. Each input transfer carries one line edge
// timestamp; the block takes one edge per clock while its queue (two entries by
// default) has room. The interval of a parity edge goes into the queue, and the
// frame it completes is registered in the output register once popped. The
// front classifies intervals combinationally (one 32-bit subtract and parallel
// compares), the back runs the frame sequencer one queued interval per cycle;
// a result that is not taken holds the back, and the queue then fills and
// stalls s_ready. Glitch edges are accepted and discarded. Configuration
// writes take effect at once and belong only to idle periods.
module pulse_width_telegram_decoder #(
    parameter int QUEUE_DEPTH = pwtd_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [pwtd_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pwtd_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic [31:0]                      s_edge_time_us,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [31:0]                      m_frame_word,
    output logic                             m_long_frame,
    output logic                             m_is_reply,
    output logic                             m_is_repeat
);
    import pwtd_pkg::*;

    token_t push_token, head_token;
    logic   push, full, pop, head_valid;

    // classify edges
    pwtd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_edge_time_us (s_edge_time_us),
        .q_full         (full),
        .q_push         (push),
        .q_token        (push_token)
    );

    // decouple front and back
    pwtd_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_token (push_token),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    // frame sequencer and result register
    pwtd_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .in_valid     (head_valid),
        .in_token     (head_token),
        .in_pop       (pop),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_frame_word (m_frame_word),
        .m_long_frame (m_long_frame),
        .m_is_reply   (m_is_reply),
        .m_is_repeat  (m_is_repeat)
    );

endmodule

/* tb/sv/pulse_width_telegram_decoder_tb.sv */
`timescale 1ns / 100ps

module pulse_width_telegram_decoder_tb;

    import pwtd_pkg::*;

    localparam int HOLD_CYCLES    = 600;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DIR_ROWS       = 26;

    // one decoded telegram as it leaves the block
    typedef struct packed {
        logic [31:0] word;
        logic        long_frame;
        logic        is_reply;
        logic        is_repeat;
    } telegram_t;

    // directed row: time step from the previous edge, optional hand-typed telegram
    typedef struct packed {
        logic [31:0] step_us;
        logic        hand;
        telegram_t   res;
    } dir_row_t;

    localparam telegram_t NO_TG = '0;
    localparam telegram_t DIR_FRAME = '{word: 32'h0000_C35A, long_frame: 1'b0,
                                        is_reply: 1'b0, is_repeat: 1'b0};

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_wdata = '0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    logic [31:0]            s_edge_time_us = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    logic [31:0]            m_frame_word;
    logic                   m_long_frame;
    logic                   m_is_reply;
    logic                   m_is_repeat;

    // shadow of the timing registers
    logic [15:0] timing_reg [8];

    // decoder state mirrored by the predictor
    logic [31:0] dec_last_edge = '0;
    phase_t      dec_phase = PH_WAIT;
    logic [5:0]  dec_want = '0;
    logic [5:0]  dec_taken = '0;
    logic [31:0] dec_shift = '0;
    logic        dec_long = 1'b0;
    logic        dec_gap_seen = 1'b0;
    logic        dec_await = 1'b0;
    logic [31:0] dec_prev_word = '0;

    telegram_t pending_frames [$];
    dir_row_t  dir_rows [DIR_ROWS];

    int   err_count = 0;
    int   edges_sent = 0;
    int   edges_kept = 0;
    int   frames_checked = 0;
    int   n_long = 0;
    int   n_reply = 0;
    int   n_repeat = 0;
    int   quiet_cycles = 0;
    int   src_idle_pct = 0;
    int   sink_stall_pct = 0;
    logic hold_req = 1'b0;
    logic hold_done = 1'b0;

    pulse_width_telegram_decoder u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_edge_time_us (s_edge_time_us),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_frame_word   (m_frame_word),
        .m_long_frame   (m_long_frame),
        .m_is_reply     (m_is_reply),
        .m_is_repeat    (m_is_repeat)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // predictor: apply one edge, return 1 when a telegram is completed
    function automatic logic decode_edge(input logic [31:0] now, output telegram_t res);
        logic [31:0] span;
        logic        bit_ok;
        logic        bit_v;
        logic        good;
        logic        reply;
        span = now - dec_last_edge;
        res = NO_TG;
        if (span < timing_reg[CFG_GLITCH_MIN])
            return 1'b0;
        edges_kept++;
        dec_last_edge = now;

        // classify, zero wins over one
        bit_ok = 1'b1;
        bit_v = 1'b0;
        if (span >= timing_reg[CFG_ZERO_MIN] && span <= timing_reg[CFG_ZERO_MAX])
            bit_v = 1'b0;
        else if (span >= timing_reg[CFG_ONE_MIN] && span <= timing_reg[CFG_ONE_MAX])
            bit_v = 1'b1;
        else
            bit_ok = 1'b0;

        // reply timeout and repeat gap tracking
        if (span > timing_reg[CFG_REPLY_TMO])
            dec_await = 1'b0;
        if (span >= GAP_MIN_US && span <= GAP_MAX_US)
            dec_gap_seen = 1'b1;
        else if (span > GAP_MAX_US)
            dec_gap_seen = 1'b0;

        // start pulse restarts the frame from any phase
        if (span >= timing_reg[CFG_START_MIN] && span <= timing_reg[CFG_START_MAX]) begin
            dec_shift = '0;
            dec_long = 1'b0;
            dec_taken = '0;
            dec_phase = PH_LENGTH;
            return 1'b0;
        end
        if (dec_phase == PH_WAIT)
            return 1'b0;
        if (!bit_ok) begin
            dec_phase = PH_WAIT;
            return 1'b0;
        end

        case (dec_phase)
            PH_LENGTH: begin
                dec_long = bit_v;
                dec_want = bit_v ? BITS_LONG : (dec_await ? BITS_REPLY : BITS_SHORT);
                dec_taken = '0;
                dec_phase = PH_DATA;
                return 1'b0;
            end
            PH_DATA: begin
                dec_shift = {dec_shift[30:0], bit_v};
                dec_taken = dec_taken + 6'd1;
                if (dec_taken >= dec_want)
                    dec_phase = PH_PARITY;
                return 1'b0;
            end
            default: begin
                // odd parity over data and parity bit
                good = ((^dec_shift) ^ 1'b1) == bit_v;
                reply = (dec_want == BITS_REPLY) || (dec_want == BITS_LONG && dec_await);
                dec_phase = PH_WAIT;
                if (!good)
                    return 1'b0;
                res.word = dec_shift;
                res.long_frame = dec_long;
                res.is_reply = reply;
                res.is_repeat = (dec_prev_word == dec_shift) && dec_gap_seen;
                dec_prev_word = dec_shift;
                dec_gap_seen = 1'b0;
                dec_await = !reply;
                return 1'b1;
            end
        endcase
    endfunction

    // random interval inside the given bit's window under the current timing
    function automatic logic [31:0] bit_span(input logic b);
        if (b)
            return $urandom_range(timing_reg[CFG_ONE_MAX], timing_reg[CFG_ONE_MIN]);
        return $urandom_range(timing_reg[CFG_ZERO_MAX], timing_reg[CFG_ZERO_MIN]);
    endfunction

    // offer one edge, hold it until the transfer, then predict
    task automatic send_edge(input logic [31:0] stamp, input logic hand,
                             input telegram_t hand_res);
        telegram_t got;
        logic      made;
        while ($urandom_range(99) < src_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_edge_time_us <= stamp;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        edges_sent++;
        made = decode_edge(stamp, got);
        if (hand)
            pending_frames.insert(pending_frames.size(), hand_res);
        else if (made)
            pending_frames.insert(pending_frames.size(), got);
    endtask

    // edge at a given interval after the last kept edge, sometimes behind a glitch
    task automatic send_span(input logic [31:0] span);
        if (timing_reg[CFG_GLITCH_MIN] != 16'd0 && $urandom_range(99) < 4)
            send_edge(dec_last_edge + $urandom_range(timing_reg[CFG_GLITCH_MIN] - 16'd1, 0),
                      1'b0, NO_TG);
        send_edge(dec_last_edge + span, 1'b0, NO_TG);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        timing_reg[idx] = val;
    endtask

    task automatic set_timing(input logic [15:0] glitch, zmin, zmax, omin, omax,
                              smin, smax, tmo);
        write_reg(CFG_GLITCH_MIN, glitch);
        write_reg(CFG_ZERO_MIN, zmin);
        write_reg(CFG_ZERO_MAX, zmax);
        write_reg(CFG_ONE_MIN, omin);
        write_reg(CFG_ONE_MAX, omax);
        write_reg(CFG_START_MIN, smin);
        write_reg(CFG_START_MAX, smax);
        write_reg(CFG_REPLY_TMO, tmo);
        cfg_we <= 1'b0;
    endtask

    // stop offering, let every telegram out, then let the queue settle
    task automatic wait_idle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_frames.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // mostly well-formed frames with random content, plus noise and broken frames
    task automatic run_random(input int n);
        int          goal;
        int          nbits;
        int          i;
        int          pick;
        logic        lng;
        logic        pbit;
        logic [31:0] word;
        goal = edges_kept + n;
        while (edges_kept < goal) begin
            pick = $urandom_range(99);
            if (pick < 15) begin
                // noise edges
                case ($urandom_range(2))
                    0: send_edge($urandom(), 1'b0, NO_TG);
                    1: send_span($urandom_range(70000, 0));
                    default: send_span($urandom_range(32'hFFFF_FFFF, GAP_MAX_US + 1));
                endcase
            end else begin
                // optional quiet time ahead of the frame
                pick = $urandom_range(9);
                if (pick < 3)
                    send_span($urandom_range(GAP_MAX_US, GAP_MIN_US));
                else if (pick == 3)
                    send_span($urandom_range(32'hFFFF_FFFF, GAP_MAX_US + 1));
                send_span($urandom_range(timing_reg[CFG_START_MAX], timing_reg[CFG_START_MIN]));
                lng = 1'($urandom_range(1));
                send_span(bit_span(lng));
                nbits = int'(dec_want);
                word = ($urandom_range(3) == 0) ? dec_prev_word : $urandom();
                for (i = nbits - 1; i >= 0; i--) begin
                    if ($urandom_range(99) < 2)
                        send_span($urandom_range(70000, 0));
                    else
                        send_span(bit_span(word[i]));
                end
                pbit = ~(^dec_shift);
                if ($urandom_range(9) == 0)
                    pbit = ~pbit;
                send_span(bit_span(pbit));
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_req && !hold_done) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
                hold_done = 1'b1;
            end
            m_ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    // compare each result transfer with the oldest predicted telegram
    always @(posedge aclk) begin
        telegram_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_frames.size() == 0) begin
                $error("result with no telegram pending: frame_word %h", m_frame_word);
                err_count++;
            end else begin
                want = pending_frames.pop_front();
                frames_checked++;
                n_long += want.long_frame;
                n_reply += want.is_reply;
                n_repeat += want.is_repeat;
                if (m_frame_word !== want.word) begin
                    $error("frame_word: expected %h, got %h", want.word, m_frame_word);
                    err_count++;
                end
                if (m_long_frame !== want.long_frame) begin
                    $error("long_frame: expected %b, got %b", want.long_frame, m_long_frame);
                    err_count++;
                end
                if (m_is_reply !== want.is_reply) begin
                    $error("is_reply: expected %b, got %b", want.is_reply, m_is_reply);
                    err_count++;
                end
                if (m_is_repeat !== want.is_repeat) begin
                    $error("is_repeat: expected %b, got %b", want.is_repeat, m_is_repeat);
                    err_count++;
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial begin
        logic [31:0] stamp;
        int          ph;
        int          g;
        int          zl;
        int          zh;
        int          ol;
        int          oh;
        int          sl;
        int          sh;
        timing_reg[CFG_GLITCH_MIN] = RST_GLITCH_MIN;
        timing_reg[CFG_ZERO_MIN]   = RST_ZERO_MIN;
        timing_reg[CFG_ZERO_MAX]   = RST_ZERO_MAX;
        timing_reg[CFG_ONE_MIN]    = RST_ONE_MIN;
        timing_reg[CFG_ONE_MAX]    = RST_ONE_MAX;
        timing_reg[CFG_START_MIN]  = RST_START_MIN;
        timing_reg[CFG_START_MAX]  = RST_START_MAX;
        timing_reg[CFG_REPLY_TMO]  = RST_REPLY_TMO;

        // directed edges under reset timing, word C35A as a short frame
        dir_rows = '{
            '{32'd0,          1'b0, NO_TG},     // span zero, dropped
            '{32'hFFFF_FFFF,  1'b0, NO_TG},     // widest span, kept while waiting
            '{32'd999,        1'b0, NO_TG},     // one below the glitch limit, wraps
            '{32'd1,          1'b0, NO_TG},     // zero bit while waiting, ignored
            '{32'd30000,      1'b0, NO_TG},     // repeat gap
            '{32'd5000,       1'b0, NO_TG},     // start, low edge
            '{32'd6999,       1'b0, NO_TG},     // start again, restarts the frame
            '{32'd2999,       1'b0, NO_TG},     // length bit zero: short frame
            '{32'd3000,       1'b0, NO_TG},
            '{32'd4999,       1'b0, NO_TG},
            '{32'd1000,       1'b0, NO_TG},
            '{32'd2999,       1'b0, NO_TG},
            '{32'd2000,       1'b0, NO_TG},
            '{32'd1000,       1'b0, NO_TG},
            '{32'd4000,       1'b0, NO_TG},
            '{32'd3000,       1'b0, NO_TG},
            '{32'd2999,       1'b0, NO_TG},
            '{32'd4999,       1'b0, NO_TG},
            '{32'd2000,       1'b0, NO_TG},
            '{32'd4000,       1'b0, NO_TG},
            '{32'd3000,       1'b0, NO_TG},
            '{32'd1000,       1'b0, NO_TG},
            '{32'd4999,       1'b0, NO_TG},
            '{32'd2999,       1'b0, NO_TG},
            '{32'd3500,       1'b1, DIR_FRAME}, // parity one, good
            '{32'd7000,       1'b0, NO_TG}      // just above start, ignored
        };

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        stamp = '0;
        for (int i = 0; i < DIR_ROWS; i++) begin
            stamp = stamp + dir_rows[i].step_us;
            send_edge(stamp, dir_rows[i].hand, dir_rows[i].res);
        end

        // long receiver hold-off while frames keep coming
        hold_req = 1'b1;
        run_random(250);

        for (ph = 1; ph < 8; ph++) begin
            wait_idle();
            case (ph)
                1: set_timing(16'd0, 16'd0, 16'd100, 16'd101, 16'd300, 16'd301, 16'd500,
                              16'd0);
                2: set_timing(16'd500, 16'd1000, 16'd4000, 16'd3000, 16'd6000, 16'd5500,
                              16'd8000, 16'hFFFF);
                3: set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                              16'hFFFF, 16'hFFFF);
                6: set_timing(RST_GLITCH_MIN, RST_ZERO_MIN, RST_ZERO_MAX, RST_ONE_MIN,
                              RST_ONE_MAX, RST_START_MIN, RST_START_MAX, RST_REPLY_TMO);
                default: begin
                    g  = $urandom_range(1500, 0);
                    zl = $urandom_range(1500, 0);
                    zh = zl + $urandom_range(3000, 0);
                    ol = zh + $urandom_range(400, 0);
                    oh = ol + $urandom_range(3000, 100);
                    sl = oh - 50 + $urandom_range(600, 0);
                    sh = sl + $urandom_range(3000, 0);
                    set_timing(16'(g), 16'(zl), 16'(zh), 16'(ol), 16'(oh), 16'(sl),
                               16'(sh), 16'($urandom_range(65535, 5000)));
                end
            endcase
            case (ph % 4)
                0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin src_idle_pct = 68; sink_stall_pct = 0;  end
                2: begin src_idle_pct = 0;  sink_stall_pct = 68; end
                default: begin src_idle_pct = 30; sink_stall_pct = 30; end
            endcase
            run_random(ph == 3 ? 80 : 250);
        end
        wait_idle();

        $display("covered %0d edges (%0d under the glitch limit) across 8 timing setups",
                 edges_sent, edges_sent - edges_kept);
        $display("%0d telegrams compared: %0d long, %0d reply, %0d repeat",
                 frames_checked, n_long, n_reply, n_repeat);
        if (err_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* pulse_width_telegram_decoder.f */
hdl/pwtd_pkg.sv
hdl/pwtd_front.sv
hdl/pwtd_queue.sv
hdl/pwtd_back.sv
hdl/pulse_width_telegram_decoder.sv
tb/sv/pulse_width_telegram_decoder_tb.sv
